FILE: rtl/sorted_list_insert_pop_filter_macros.svh
// ----------------------------------------------------------------------------
// Sorted list insert/pop/filter - assertion macros
// Clocked assertion helpers, reset-qualified on arst_n.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_POP_FILTER_MACROS_SVH
`define SORTED_LIST_INSERT_POP_FILTER_MACROS_SVH

// same-cycle implication
`define SLIPF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SLIPF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/slipf_pkg.sv
// ----------------------------------------------------------------------------
// slipf_pkg
// Types and constants shared by the sorted list controller and datapath.
// ----------------------------------------------------------------------------
package slipf_pkg;

	localparam int DEF_STORE_DEPTH = 16;

	// request codes
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_POP    = 2'd1;
	localparam logic [1:0] REQ_FILTER = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_FULL    = 2'd1;
	localparam logic [1:0] STAT_EMPTY   = 2'd2;
	localparam logic [1:0] STAT_NOMATCH = 2'd3;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] in_value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] out_value;
		logic [1:0]         status;
		logic               last;
	} rsp_t;

	typedef enum logic [1:0] {
		CTL_IDLE,
		CTL_SCAN,
		CTL_FLUSH
	} ctl_state_t;

	typedef struct packed {
		logic ins;
		logic pop;
		logic scan_start;
		logic scan_step;
		logic flush;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_last;
	} dp_stat_t;

endpackage

FILE: rtl/slipf_ctrl.sv
// ----------------------------------------------------------------------------
// slipf_ctrl
// Request sequencer: issues insert/pop in the accept cycle, walks the filter
// scan over the store and closes it with a flush step.
// ----------------------------------------------------------------------------
module slipf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [1:0]           req_type,
	input  slipf_pkg::dp_stat_t  stat,
	output logic                 busy,
	output slipf_pkg::dp_cmd_t   cmd
);
	import slipf_pkg::*;

	ctl_state_t state_q, state_nxt;
	logic       accept;

	assign accept = start && (state_q == CTL_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CTL_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			CTL_IDLE: begin
				if (accept && req_type == REQ_FILTER) begin
					state_nxt = CTL_SCAN;
				end
			end
			CTL_SCAN: begin
				if (stat.scan_last) begin
					state_nxt = CTL_FLUSH;
				end
			end
			CTL_FLUSH: begin
				state_nxt = CTL_IDLE;
			end
			default: begin
				state_nxt = CTL_IDLE;
			end
		endcase
	end

	always_comb begin
		busy = 1'b1;
		cmd  = '0;
		unique case (state_q)
			CTL_IDLE: begin
				busy           = 1'b0;
				cmd.ins        = accept && (req_type == REQ_INSERT);
				cmd.pop        = accept && (req_type == REQ_POP);
				cmd.scan_start = accept && (req_type == REQ_FILTER);
			end
			CTL_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			CTL_FLUSH: begin
				cmd.flush = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

FILE: rtl/slipf_dp.sv
// ----------------------------------------------------------------------------
// slipf_dp
// Cell array holding the sorted values top-aligned (largest in the top cell),
// with per-cell compare/shift, scan rotation and the result register.
// ----------------------------------------------------------------------------
module slipf_dp #(
	parameter int STORE_DEPTH = slipf_pkg::DEF_STORE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  slipf_pkg::dp_cmd_t   cmd,
	input  logic signed [31:0]   in_value,
	output slipf_pkg::dp_stat_t  stat,
	output logic                 done,
	output slipf_pkg::rsp_t      rsp
);
	import slipf_pkg::*;

	localparam int CW = $clog2(STORE_DEPTH + 1);
	localparam int KW = $clog2(STORE_DEPTH);

	// tests whether the value is a multiple of 3, via base-4 digit sums (4 = 1 mod 3)
	function automatic logic mult3(input logic [31:0] b);
		logic [2:0] l1 [8];
		logic [3:0] l2 [4];
		logic [4:0] l3 [2];
		logic [5:0] s;
		logic [3:0] d;
		logic [2:0] e;
		logic [1:0] r;
		for (int j = 0; j < 8; j++) begin
			l1[j] = {1'b0, b[4*j +: 2]} + {1'b0, b[4*j+2 +: 2]};
		end
		for (int j = 0; j < 4; j++) begin
			l2[j] = {1'b0, l1[2*j]} + {1'b0, l1[2*j+1]};
		end
		for (int j = 0; j < 2; j++) begin
			l3[j] = {1'b0, l2[2*j]} + {1'b0, l2[2*j+1]};
		end
		s = {1'b0, l3[0]} + {1'b0, l3[1]};
		d = {2'b0, s[1:0]} + {2'b0, s[3:2]} + {2'b0, s[5:4]};
		e = {1'b0, d[1:0]} + {1'b0, d[3:2]};
		case (e) inside
			3'd0, 3'd3: r = 2'd0;
			3'd1, 3'd4: r = 2'd1;
			default:    r = 2'd2;
		endcase
		// two's complement word is x + 2^32 and 2^32 = 1 mod 3
		return b[31] ? (r == 2'd1) : (r == 2'd0);
	endfunction

	logic signed [31:0]     cells_q [STORE_DEPTH];
	logic [CW-1:0]          cnt_q;
	logic [KW-1:0]          k_q;
	logic                   pend_vld_q;
	logic signed [31:0]     pend_q;
	logic                   done_q;
	rsp_t                   rsp_q;

	logic [STORE_DEPTH-1:0] valid_w;
	logic [STORE_DEPTH-1:0] gt_w;
	logic                   full;
	logic                   empty;
	logic                   scan_vld;
	logic                   scan_hit;

	assign full     = (cnt_q == CW'(STORE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign scan_vld = (CW'(STORE_DEPTH) - CW'(k_q)) <= cnt_q;
	assign scan_hit = scan_vld && mult3(cells_q[0]);

	assign stat.scan_last = (k_q == KW'(STORE_DEPTH - 1));

	for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_cell
		localparam int UP = (g + 1) % STORE_DEPTH;
		localparam int DN = (g + STORE_DEPTH - 1) % STORE_DEPTH;
		logic gt_up;

		// valid entries occupy the top cnt cells
		assign valid_w[g] = CW'(STORE_DEPTH - g) <= cnt_q;
		assign gt_w[g]    = valid_w[g] && (cells_q[g] > in_value);

		if (g == STORE_DEPTH - 1) begin : g_top
			assign gt_up = 1'b1;
		end else begin : g_mid
			assign gt_up = gt_w[g+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.ins && !full) begin
				// larger values stay, the rest slide down one cell
				if (!gt_w[g]) begin
					cells_q[g] <= gt_up ? in_value : cells_q[UP];
				end
			end else if (cmd.pop && !empty) begin
				cells_q[g] <= cells_q[DN];
			end else if (cmd.scan_step) begin
				cells_q[g] <= cells_q[UP];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			k_q        <= '0;
			pend_vld_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			// a scan hit releases the match held from before, if any
			done_q <= cmd.ins || cmd.pop || cmd.flush ||
				(cmd.scan_step && scan_hit && pend_vld_q);
			if (cmd.ins) begin
				if (!full) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.pop) begin
				if (!empty) begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
			if (cmd.scan_start) begin
				k_q        <= '0;
				pend_vld_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				k_q <= k_q + 1'b1;
				if (scan_hit) begin
					// hold one match back so the final one can carry last
					pend_vld_q <= 1'b1;
				end
			end
			if (cmd.flush) begin
				pend_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			rsp_q <= '{out_value: '0, status: full ? STAT_FULL : STAT_OK, last: 1'b1};
		end
		if (cmd.pop) begin
			if (empty) begin
				rsp_q <= '{out_value: '0, status: STAT_EMPTY, last: 1'b1};
			end else begin
				rsp_q <= '{out_value: cells_q[STORE_DEPTH-1], status: STAT_OK, last: 1'b1};
			end
		end
		if (cmd.scan_step && scan_hit) begin
			rsp_q  <= '{out_value: pend_q, status: STAT_OK, last: 1'b0};
			pend_q <= cells_q[0];
		end
		if (cmd.flush) begin
			if (pend_vld_q) begin
				rsp_q <= '{out_value: pend_q, status: STAT_OK, last: 1'b1};
			end else begin
				rsp_q <= '{out_value: '0, status: STAT_NOMATCH, last: 1'b1};
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

FILE: rtl/sorted_list_insert_pop_filter.sv
// Insert and pop: result strobed the cycle after the request, busy stays low,
// so a new request may follow every cycle. Filter: busy while the cell array
// rotates once past the scan tap; at most one match per cycle, the final
// result (flagged last) strobed in the first cycle busy is low again. Async
// reset empties the store (count to zero) and idles the sequencer; results
// are never stalled.
// ----------------------------------------------------------------------------
// sorted_list_insert_pop_filter
// Bounded ascending sorted store with insert, pop-largest and mult-of-3 filter.
// ----------------------------------------------------------------------------
module sorted_list_insert_pop_filter #(
	parameter int STORE_DEPTH = slipf_pkg::DEF_STORE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  slipf_pkg::req_t  req,
	output logic             busy,
	output logic             done,
	output slipf_pkg::rsp_t  rsp
);
	import slipf_pkg::*;

	`include "sorted_list_insert_pop_filter_macros.svh"

	dp_cmd_t  cmd;
	dp_stat_t stat;

	slipf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req.req_type),
		.stat     (stat),
		.busy     (busy),
		.cmd      (cmd)
	);

	slipf_dp #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_value (req.in_value),
		.stat     (stat),
		.done     (done),
		.rsp      (rsp)
	);

	`SLIPF_ASSERT_NEXT(a_ins_result, start && !busy && req.req_type == REQ_INSERT, done && rsp.last && rsp.out_value == 0, "insert request gave no single result")
	`SLIPF_ASSERT_NEXT(a_filter_busy, start && !busy && req.req_type == REQ_FILTER, busy && !done, "filter request did not start a scan")
	`SLIPF_ASSERT_NOW(a_scan_close, $fell(busy), done && rsp.last, "filter scan ended without a final result")
	`SLIPF_ASSERT_NOW(a_cmd_excl, 1'b1, $onehot0({cmd.ins, cmd.pop, cmd.scan_start, cmd.scan_step, cmd.flush}), "conflicting datapath commands")

endmodule
